// ----- hdl/spe_pkg.sv -----
package spe_pkg;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_NEXT  = 2'd2
  } act_t;

  typedef enum logic [1:0] {
    ST_ELEM      = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    U_NOP,
    U_CLEAR,
    U_KLOAD,
    U_KDEC,
    U_RD_SWAP,
    U_WR_A,
    U_WR_B,
    U_APPEND,
    U_REJECT,
    U_INIT,
    U_STK_INC,
    U_STK_FILL,
    U_FAIL,
    U_EXHAUSTED,
    U_PRIME,
    U_STREAM
  } uop_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_FULL,
    C_KZERO,
    C_DONE,
    C_STARTED,
    C_IDX_GE_N,
    C_PMORE
  } cond_t;

  typedef logic [4:0] upc_t;

  typedef struct packed {
    uop_t  op;
    cond_t cond;
    upc_t  target;
  } uword_t;

  typedef struct packed {
    logic full;
    logic kzero;
    logic done;
    logic started;
    logic idx_ge_n;
    logic pmore;
  } flags_t;

  // microprogram entry points and loop heads
  localparam upc_t A_IDLE    = 5'd0;
  localparam upc_t A_CLR     = 5'd1;
  localparam upc_t A_LD      = 5'd2;
  localparam upc_t A_LD_LOOP = 5'd3;
  localparam upc_t A_APP     = 5'd8;
  localparam upc_t A_REJ     = 5'd9;
  localparam upc_t A_NX      = 5'd10;
  localparam upc_t A_BT      = 5'd13;
  localparam upc_t A_BT_LOOP = 5'd14;
  localparam upc_t A_FAIL    = 5'd25;
  localparam upc_t A_NEX     = 5'd26;
  localparam upc_t A_EM      = 5'd27;
  localparam upc_t A_ST      = 5'd28;

  function automatic uword_t mk_uword(uop_t op, cond_t c, upc_t t);
    return '{op: op, cond: c, target: t};
  endfunction

  function automatic uword_t ucode(upc_t a);
    uword_t w;
    unique case (a)
      5'd0:  w = mk_uword(U_NOP,       C_NEVER,    A_IDLE);
      5'd1:  w = mk_uword(U_CLEAR,     C_ALWAYS,   A_IDLE);
      // load: reject if full, else undo live swaps, then append
      5'd2:  w = mk_uword(U_KLOAD,     C_FULL,     A_REJ);
      5'd3:  w = mk_uword(U_NOP,       C_KZERO,    A_APP);
      5'd4:  w = mk_uword(U_KDEC,      C_NEVER,    A_IDLE);
      5'd5:  w = mk_uword(U_RD_SWAP,   C_NEVER,    A_IDLE);
      5'd6:  w = mk_uword(U_WR_A,      C_NEVER,    A_IDLE);
      5'd7:  w = mk_uword(U_WR_B,      C_ALWAYS,   A_LD_LOOP);
      5'd8:  w = mk_uword(U_APPEND,    C_ALWAYS,   A_IDLE);
      5'd9:  w = mk_uword(U_REJECT,    C_ALWAYS,   A_IDLE);
      // next
      5'd10: w = mk_uword(U_NOP,       C_DONE,     A_NEX);
      5'd11: w = mk_uword(U_NOP,       C_STARTED,  A_BT);
      5'd12: w = mk_uword(U_INIT,      C_ALWAYS,   A_EM);
      5'd13: w = mk_uword(U_KLOAD,     C_NEVER,    A_IDLE);
      5'd14: w = mk_uword(U_NOP,       C_KZERO,    A_FAIL);
      5'd15: w = mk_uword(U_KDEC,      C_NEVER,    A_IDLE);
      5'd16: w = mk_uword(U_RD_SWAP,   C_NEVER,    A_IDLE);
      5'd17: w = mk_uword(U_WR_A,      C_NEVER,    A_IDLE);
      5'd18: w = mk_uword(U_WR_B,      C_NEVER,    A_IDLE);
      5'd19: w = mk_uword(U_STK_INC,   C_NEVER,    A_IDLE);
      5'd20: w = mk_uword(U_NOP,       C_IDX_GE_N, A_BT_LOOP);
      5'd21: w = mk_uword(U_RD_SWAP,   C_NEVER,    A_IDLE);
      5'd22: w = mk_uword(U_WR_A,      C_NEVER,    A_IDLE);
      5'd23: w = mk_uword(U_WR_B,      C_NEVER,    A_IDLE);
      5'd24: w = mk_uword(U_STK_FILL,  C_ALWAYS,   A_EM);
      5'd25: w = mk_uword(U_FAIL,      C_NEVER,    A_IDLE);
      5'd26: w = mk_uword(U_EXHAUSTED, C_ALWAYS,   A_IDLE);
      // emit: one word per cycle from the element RAM
      5'd27: w = mk_uword(U_PRIME,     C_NEVER,    A_IDLE);
      5'd28: w = mk_uword(U_STREAM,    C_PMORE,    A_ST);
      5'd29: w = mk_uword(U_NOP,       C_ALWAYS,   A_IDLE);
      default: w = mk_uword(U_NOP,     C_ALWAYS,   A_IDLE);
    endcase
    return w;
  endfunction

  function automatic upc_t dispatch(logic [1:0] action);
    upc_t a;
    unique case (action)
      ACT_CLEAR: a = A_CLR;
      ACT_LOAD:  a = A_LD;
      ACT_NEXT:  a = A_NX;
      default:   a = A_IDLE;
    endcase
    return a;
  endfunction

endpackage

// ----- hdl/spe_ram.sv -----
module spe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ----- hdl/spe_useq.sv -----
module spe_useq
  import spe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] action,
  input  flags_t     flags,
  output logic       busy,
  output uop_t       op
);

  upc_t   upc_r, upc_nxt;
  uword_t uw;
  logic   take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= A_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  always_comb begin
    uw   = ucode(upc_r);
    busy = (upc_r != A_IDLE);
    op   = uw.op;
    case (uw.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_FULL:     take = flags.full;
      C_KZERO:    take = flags.kzero;
      C_DONE:     take = flags.done;
      C_STARTED:  take = flags.started;
      C_IDX_GE_N: take = flags.idx_ge_n;
      C_PMORE:    take = flags.pmore;
      default:    take = 1'b0;
    endcase
    if (!busy) begin
      upc_nxt = start ? dispatch(action) : A_IDLE;
    end else if (take) begin
      upc_nxt = uw.target;
    end else begin
      upc_nxt = upc_r + upc_t'(1);
    end
  end

endmodule

// ----- hdl/swap_permutation_enumerator.sv -----
// Swap-recursion permutation enumerator.
// Command port: a word (in_action, in_value) is taken on a clock edge with
// start high and busy low. Actions: clear empties the store; load appends
// in_value and restarts enumeration at load order; next emits the following
// permutation. Results leave on out_* for one cycle each, marked by
// out_strobe; the receiver cannot stall them and none is held back.
// A next emits n words (positions 0..n-1, out_final_flag on the last) or one
// exhausted word; a load on a full store emits one rejected word.
// Steps, with n elements and L live recursion levels (L <= n-1):
//   clear: empties the store, no results.
//   load:  undoes L swaps, then appends, no results; a full store rejects.
//   next:  the first permutation is initialised and streamed; later ones
//          back over levels and advance levels before streaming; words
//          stream one per cycle, each in the cycle after its microcode step.
// Every element swap takes a read step and two writes on the single write port of the
// element RAM; that port and the microcode sequencer set the rate.
// Reset clears the count, the level pointer and the flags; the element
// store itself holds no reset value and is written before it is read.
module swap_permutation_enumerator
  import spe_pkg::*;
#(
  parameter int N_MAX      = 8,
  parameter int VALUE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_action,
  input  logic signed [15:0] in_value,
  output logic               out_strobe,
  output logic [1:0]         out_status,
  output logic signed [15:0] out_element,
  output logic [2:0]         out_position,
  output logic               out_final_flag
);

  localparam int CW = $clog2(N_MAX + 1);
  localparam int AW = (N_MAX > 1) ? $clog2(N_MAX) : 1;

  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         lp_r, lp_nxt;
  logic [CW-1:0]         k_r, k_nxt;
  logic [CW-1:0]         p_r, p_nxt;
  logic                  started_r, started_nxt;
  logic                  exh_r, exh_nxt;
  logic [VALUE_BITS-1:0] value_r;
  logic [CW-1:0]         stk_r [N_MAX];
  logic [CW-1:0]         stk_nxt [N_MAX];
  logic [CW-1:0]         stk_cur;

  logic                  out_strobe_r, out_strobe_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [15:0]           out_element_r, out_element_nxt;
  logic [2:0]            out_position_r, out_position_nxt;
  logic                  out_final_flag_r, out_final_flag_nxt;

  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_ra, ram_rb;
  logic [VALUE_BITS-1:0] ram_wdata, ram_da, ram_db;

  logic [VALUE_BITS+15:0] val_ext, elem_ext;
  logic [CW+2:0]          pos_w;
  logic                   accept;
  flags_t                 flags;
  uop_t                   op;

  spe_useq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .action (in_action),
    .flags  (flags),
    .busy   (busy),
    .op     (op)
  );

  spe_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (N_MAX)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr_a (ram_ra),
    .raddr_b (ram_rb),
    .rdata_a (ram_da),
    .rdata_b (ram_db)
  );

  assign accept   = start && !busy;
  assign val_ext  = {{VALUE_BITS{1'b0}}, in_value};
  assign elem_ext = {16'd0, ram_da};
  assign pos_w    = (CW + 3)'(p_r) - (CW + 3)'(1);
  assign stk_cur  = stk_r[k_r[AW-1:0]];

  always_comb begin
    flags.full     = (count_r == CW'(N_MAX));
    flags.kzero    = (k_r == '0);
    flags.done     = exh_r || (count_r == '0);
    flags.started  = started_r;
    flags.idx_ge_n = (stk_cur >= count_r);
    flags.pmore    = (p_r != count_r);
  end

  // level index stack
  always_comb begin
    for (int j = 0; j < N_MAX; j++) begin
      stk_nxt[j] = stk_r[j];
    end
    case (op)
      U_INIT: begin
        for (int j = 0; j < N_MAX; j++) begin
          stk_nxt[j] = CW'(j);
        end
      end
      U_STK_INC: begin
        stk_nxt[k_r[AW-1:0]] = stk_cur + CW'(1);
      end
      U_STK_FILL: begin
        for (int j = 0; j < N_MAX; j++) begin
          if (CW'(j) > k_r) begin
            stk_nxt[j] = CW'(j);
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    count_nxt          = count_r;
    lp_nxt             = lp_r;
    k_nxt              = k_r;
    p_nxt              = p_r;
    started_nxt        = started_r;
    exh_nxt            = exh_r;
    ram_we             = 1'b0;
    ram_waddr          = k_r[AW-1:0];
    ram_wdata          = ram_db;
    ram_re             = 1'b0;
    ram_ra             = k_r[AW-1:0];
    ram_rb             = stk_cur[AW-1:0];
    out_strobe_nxt     = 1'b0;
    out_status_nxt     = ST_ELEM;
    out_element_nxt    = '0;
    out_position_nxt   = '0;
    out_final_flag_nxt = 1'b0;
    unique case (op)
      U_CLEAR: begin
        count_nxt   = '0;
        lp_nxt      = '0;
        started_nxt = 1'b0;
        exh_nxt     = 1'b0;
      end
      U_KLOAD:   k_nxt = lp_r;
      U_KDEC:    k_nxt = k_r - CW'(1);
      U_RD_SWAP: ram_re = 1'b1;
      U_WR_A: begin
        ram_we    = 1'b1;
        ram_wdata = ram_db;
      end
      U_WR_B: begin
        ram_we    = 1'b1;
        ram_waddr = stk_cur[AW-1:0];
        ram_wdata = ram_da;
      end
      U_APPEND: begin
        ram_we      = 1'b1;
        ram_waddr   = count_r[AW-1:0];
        ram_wdata   = value_r;
        count_nxt   = count_r + CW'(1);
        lp_nxt      = '0;
        started_nxt = 1'b0;
        exh_nxt     = 1'b0;
      end
      U_REJECT: begin
        out_strobe_nxt     = 1'b1;
        out_status_nxt     = ST_FULL;
        out_final_flag_nxt = 1'b1;
      end
      U_INIT: begin
        started_nxt = 1'b1;
        lp_nxt      = count_r - CW'(1);
      end
      U_FAIL: lp_nxt = '0;
      U_EXHAUSTED: begin
        exh_nxt            = 1'b1;
        out_strobe_nxt     = 1'b1;
        out_status_nxt     = ST_EXHAUSTED;
        out_final_flag_nxt = 1'b1;
      end
      U_PRIME: begin
        ram_re = 1'b1;
        ram_ra = '0;
        p_nxt  = CW'(1);
      end
      // read word p while the word at p-1 goes out
      U_STREAM: begin
        ram_re             = 1'b1;
        ram_ra             = p_r[AW-1:0];
        p_nxt              = p_r + CW'(1);
        out_strobe_nxt     = 1'b1;
        out_element_nxt    = elem_ext[15:0];
        out_position_nxt   = pos_w[2:0];
        out_final_flag_nxt = (p_r == count_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      lp_r         <= '0;
      started_r    <= 1'b0;
      exh_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      lp_r         <= lp_nxt;
      started_r    <= started_nxt;
      exh_r        <= exh_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r              <= k_nxt;
    p_r              <= p_nxt;
    out_status_r     <= out_status_nxt;
    out_element_r    <= out_element_nxt;
    out_position_r   <= out_position_nxt;
    out_final_flag_r <= out_final_flag_nxt;
    for (int j = 0; j < N_MAX; j++) begin
      stk_r[j] <= stk_nxt[j];
    end
    if (accept) begin
      value_r <= val_ext[VALUE_BITS-1:0];
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_status     = out_status_r;
  assign out_element    = out_element_r;
  assign out_position   = out_position_r;
  assign out_final_flag = out_final_flag_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(N_MAX))
    else $error("element count above capacity");

  a_unstarted_no_levels: assert property (@(posedge clk) disable iff (!rst_n)
    !started_r |-> lp_r == '0)
    else $error("live levels without a started run");

  a_exhausted_no_levels: assert property (@(posedge clk) disable iff (!rst_n)
    exh_r |-> lp_r == '0)
    else $error("live levels after exhaustion");

  a_status_word_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && out_status_r != ST_ELEM |-> out_final_flag_r)
    else $error("status word not flagged final");

endmodule
